@@ design/nss_pkg.sv @@
// ----------------------------------------------------------------------------
// nss_pkg: shared types and constants of the nearest station search
// Field widths, request codes, sequencer states and sizing helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

   // Payload field widths.
   localparam int COORD_W = 24;
   localparam int TAG_W   = 8;
   localparam int VALUE_W = 32;
   localparam int REQ_W   = 2;

   // Squares, radicand, root and partial remainder widths.
   localparam int SQ_W    = 2 * COORD_W;
   localparam int RAD_W   = SQ_W + 2;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int STEP_W  = $clog2(ROOT_W + 1);

   // One table entry as stored in memory.
   localparam int ENTRY_W = 2 * COORD_W + TAG_W + VALUE_W;

   // Default table capacity.
   localparam int MAX_STATIONS_DEF = 64;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // Query sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_WAIT
   } state_type;

endpackage

`default_nettype wire

@@ design/nss_ram.sv @@
// ----------------------------------------------------------------------------
// nss_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/nss_isqrt.sv @@
// ----------------------------------------------------------------------------
// nss_isqrt: iterative integer square root
// Restoring square root, one root bit per cycle, truncated result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nss_isqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [nss_pkg::RAD_W-1:0]    radicand,
   output logic                              done,
   output logic      [nss_pkg::ROOT_W-1:0]   root
);

   import nss_pkg::*;

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   // Bring down the next two radicand bits and try the next root bit.
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ design/nearest_station_search_top.sv @@
// ----------------------------------------------------------------------------
// nearest_station_search_top: brute-force 2-D nearest station lookup
// Station table in memory, walked by a sequencer with one shared multiplier
// and one iterative square root unit.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries load, query and clear items; the response
//   channel carries one result per query. A transfer happens at a clock
//   edge where valid is high and stall is low.
//   A load or clear gives no response. Loads beyond the table capacity
//   are dropped. A query walks the stored stations in load order. For
//   each station it does a memory read, the differences, two squares on
//   the shared multiplier and the square root start, then waits on the
//   25 iterations of the square root unit. An empty table answers in the
//   cycle after its request transfer with found low and zero fields.
//   The block handles one item at a time: req_stall is high while a query
//   runs and while a finished response waits in the output register, so
//   the next request transfer comes at the earliest in the cycle after the
//   response transfer. When the receiver stalls, the response holds.
//   Synchronous reset empties the table and drops any pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_station_search_top #(
   parameter int MAX_STATIONS = nss_pkg::MAX_STATIONS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [nss_pkg::REQ_W-1:0]     req_type,
   input  wire logic [nss_pkg::COORD_W-1:0]   req_coord_x,
   input  wire logic [nss_pkg::COORD_W-1:0]   req_coord_y,
   input  wire logic [nss_pkg::TAG_W-1:0]     req_station_tag,
   input  wire logic [nss_pkg::VALUE_W-1:0]   req_station_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic      [nss_pkg::TAG_W-1:0]     rsp_nearest_tag,
   output logic      [nss_pkg::VALUE_W-1:0]   rsp_nearest_value,
   output logic      [nss_pkg::ROOT_W-1:0]    rsp_min_distance
);

   import nss_pkg::*;

   localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CW = $clog2(MAX_STATIONS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [TAG_W-1:0]   cand_tag_ff;
   logic [VALUE_W-1:0] cand_value_ff;
   logic               have_ff, have_in;
   logic [ROOT_W-1:0]  best_ff, best_in;
   logic [TAG_W-1:0]   best_tag_ff, best_tag_in;
   logic [VALUE_W-1:0] best_value_ff, best_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [ROOT_W-1:0]  rsp_dist_ff;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [COORD_W-1:0] ent_x, ent_y;
   logic [TAG_W-1:0]   ent_tag;
   logic [VALUE_W-1:0] ent_value;
   logic               mul_sel_y;
   logic [COORD_W-1:0] mul_op;
   logic [SQ_W-1:0]    mul_out;
   logic               root_start;
   logic               root_done;
   logic [ROOT_W-1:0]  root_val;
   logic               last_entry;
   logic               finish;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // Station table.
   assign wr_en   = req_xfer && (req_type == REQ_LOAD) &&
                    (count_ff < CW'(MAX_STATIONS));
   assign wr_data = {req_coord_x, req_coord_y, req_station_tag, req_station_value};

   nss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_STATIONS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign {ent_x, ent_y, ent_tag, ent_value} = rd_data;

   // Shared squaring multiplier.
   assign mul_op  = mul_sel_y ? dy_ff : dx_ff;
   assign mul_out = mul_op * mul_op;

   nss_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({2'b00, sqx_ff} + {2'b00, sqy_ff}),
      .done     (root_done),
      .root     (root_val)
   );

   assign last_entry = (idx_ff + 1'b1) == count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_type == REQ_QUERY) && (count_ff != '0)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_ROOT;
         ST_ROOT: state_in = ST_WAIT;
         ST_WAIT: begin
            if (root_done) begin
               state_in = last_entry ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      rd_en      = 1'b0;
      mul_sel_y  = 1'b0;
      root_start = 1'b0;
      unique case (state_ff)
         ST_READ: rd_en      = 1'b1;
         ST_SQY:  mul_sel_y  = 1'b1;
         ST_ROOT: root_start = 1'b1;
         default: begin
         end
      endcase
   end

   // Table count, walk index and running best.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_tag_in   = best_tag_ff;
      best_value_in = best_value_ff;
      finish        = 1'b0;
      if (req_xfer) begin
         case (req_type)
            REQ_LOAD: begin
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_CLEAR: count_in = '0;
            REQ_QUERY: begin
               idx_in  = '0;
               have_in = 1'b0;
               finish  = (count_ff == '0);
            end
            default: begin
            end
         endcase
      end
      if ((state_ff == ST_WAIT) && root_done) begin
         if (!have_ff || (root_val < best_ff)) begin
            have_in       = 1'b1;
            best_in       = root_val;
            best_tag_in   = cand_tag_ff;
            best_value_in = cand_value_ff;
         end
         idx_in = idx_ff + 1'b1;
         finish = last_entry;
      end
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      have_ff       <= have_in;
      best_ff       <= best_in;
      best_tag_ff   <= best_tag_in;
      best_value_ff <= best_value_in;
   end

   // Query point, per-entry differences and squares.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
      end
      if (state_ff == ST_DIFF) begin
         dx_ff         <= (ent_x >= qx_ff) ? ent_x - qx_ff : qx_ff - ent_x;
         dy_ff         <= (ent_y >= qy_ff) ? ent_y - qy_ff : qy_ff - ent_y;
         cand_tag_ff   <= ent_tag;
         cand_value_ff <= ent_value;
      end
      if (state_ff == ST_SQX) begin
         sqx_ff <= mul_out;
      end
      if (state_ff == ST_SQY) begin
         sqy_ff <= mul_out;
      end
   end

   // Response register; an empty table reports zeros.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_found_ff <= have_in;
         rsp_tag_ff   <= have_in ? best_tag_in   : '0;
         rsp_value_ff <= have_in ? best_value_in : '0;
         rsp_dist_ff  <= have_in ? best_in       : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_tag   = rsp_tag_ff;
   assign rsp_nearest_value = rsp_value_ff;
   assign rsp_min_distance  = rsp_dist_ff;

endmodule

`default_nettype wire
